// ===== sv/prs_pkg.sv =====
`default_nettype none

package prs_pkg;

   // Default phase width: a full turn equals 2^PHASE_BITS.
   localparam int PHASE_BITS_DEFAULT = 16;

   // Directions through the centre pixel, one lane each.
   localparam int LANE_COUNT = 4;
   localparam int DIR_HORIZONTAL = 0;
   localparam int DIR_VERTICAL   = 1;
   localparam int DIR_DIAGONAL   = 2;
   localparam int DIR_ANTI_DIAG  = 3;

   // Load enables of the four pipeline stages.
   typedef struct packed {
      logic magnitude;
      logic square;
      logic pair_sum;
      logic total;
   } stage_en_type;

endpackage

`default_nettype wire

// ===== sv/prs_lane.sv =====
`default_nettype none

module prs_lane
   import prs_pkg::*;
#(
   parameter int PHASE_BITS = PHASE_BITS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire stage_en_type              stage_en,
   input  wire logic [PHASE_BITS-1:0]     phase_a,
   input  wire logic [PHASE_BITS-1:0]     phase_c,
   input  wire logic [PHASE_BITS-1:0]     phase_b,
   output logic      [2*PHASE_BITS-1:0]   square
);

   // Differences taken modulo a full turn; read as two's complement they
   // already lie in [-pi, pi), with exactly half a turn landing on -pi.
   logic [PHASE_BITS-1:0]   diff_ac;
   logic [PHASE_BITS-1:0]   diff_cb;
   logic [PHASE_BITS:0]     second_diff;
   logic [PHASE_BITS:0]     second_neg;
   logic [PHASE_BITS:0]     abs_diff;
   logic [PHASE_BITS-1:0]   mag_in;
   logic [PHASE_BITS-1:0]   mag_ff;
   logic [2*PHASE_BITS-1:0] mag_ext;
   logic [2*PHASE_BITS-1:0] square_in;
   logic [2*PHASE_BITS-1:0] square_ff;

   always_comb begin
      diff_ac     = phase_a - phase_c;
      diff_cb     = phase_c - phase_b;
      second_diff = {diff_ac[PHASE_BITS-1], diff_ac} - {diff_cb[PHASE_BITS-1], diff_cb};
      second_neg  = (PHASE_BITS+1)'(0) - second_diff;
      abs_diff    = second_diff[PHASE_BITS] ? second_neg : second_diff;
      // The magnitude never exceeds 2^PHASE_BITS - 1.
      mag_in      = abs_diff[PHASE_BITS-1:0];
      mag_ext     = {{PHASE_BITS{1'b0}}, mag_ff};
      square_in   = mag_ext * mag_ext;
   end

   always_ff @(posedge clock) begin
      if (stage_en.magnitude) begin
         mag_ff <= mag_in;
      end
      if (stage_en.square) begin
         square_ff <= square_in;
      end
   end

   assign square = square_ff;

endmodule

`default_nettype wire

// ===== sv/prs_merge.sv =====
`default_nettype none

module prs_merge
   import prs_pkg::*;
#(
   parameter int PHASE_BITS = PHASE_BITS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire stage_en_type              stage_en,
   input  wire logic [2*PHASE_BITS-1:0]   square [LANE_COUNT],
   input  wire logic                      keep,
   output logic      [2*PHASE_BITS+1:0]   total
);

   logic [2*PHASE_BITS:0]   pair_in [2];
   logic [2*PHASE_BITS:0]   pair_ff [2];
   logic [2*PHASE_BITS+1:0] total_in;
   logic [2*PHASE_BITS+1:0] total_ff;

   always_comb begin
      pair_in[0] = {1'b0, square[DIR_HORIZONTAL]} + {1'b0, square[DIR_VERTICAL]};
      pair_in[1] = {1'b0, square[DIR_DIAGONAL]} + {1'b0, square[DIR_ANTI_DIAG]};
      // A window with any masked pixel reports zero.
      total_in   = keep ? ({1'b0, pair_ff[0]} + {1'b0, pair_ff[1]})
                        : (2*PHASE_BITS+2)'(0);
   end

   always_ff @(posedge clock) begin
      if (stage_en.pair_sum) begin
         pair_ff <= pair_in;
      end
      if (stage_en.total) begin
         total_ff <= total_in;
      end
   end

   assign total = total_ff;

endmodule

`default_nettype wire

// ===== sv/phase_reliability_stencil.sv =====
// Second-difference reliability of one 3x3 window of wrapped phase.
//
// Input channel (req_): one word carries the nine phase samples of a window
// and its nine mask bits. Output channel (rsp_): one word per input word,
// with rsp_reliable high when no window pixel is masked and rsp_reliability
// holding the sum of the four squared second differences, or zero.
//
// Four lanes, one per direction through the centre, compute the wrapped
// second difference and square it; a merging stage adds the four squares.
// The pipeline has four register stages. rsp_valid rises once a word has
// passed the magnitude, square, pair-sum and total registers in turn.
// Throughput is one word per cycle while the receiver does not stall, set
// by the four-stage pipeline with one multiplier per lane; each stage carries
// its own valid bit.
//
// Reset clears every valid bit; the pipeline then accepts at once. When the
// receiver stalls, the output word holds and the stages behind it keep
// filling until every stage is occupied, so up to four words sit in flight
// before req_ready drops. A bubble anywhere lets the input advance.
`default_nettype none

module phase_reliability_stencil
   import prs_pkg::*;
#(
   parameter int PHASE_BITS = PHASE_BITS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [PHASE_BITS-1:0]   req_phase_up_left,
   input  wire logic [PHASE_BITS-1:0]   req_phase_up,
   input  wire logic [PHASE_BITS-1:0]   req_phase_up_right,
   input  wire logic [PHASE_BITS-1:0]   req_phase_left,
   input  wire logic [PHASE_BITS-1:0]   req_phase_center,
   input  wire logic [PHASE_BITS-1:0]   req_phase_right,
   input  wire logic [PHASE_BITS-1:0]   req_phase_down_left,
   input  wire logic [PHASE_BITS-1:0]   req_phase_down,
   input  wire logic [PHASE_BITS-1:0]   req_phase_down_right,
   input  wire logic [8:0]              req_window_masked,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic                         rsp_reliable,
   output logic [2*PHASE_BITS+1:0]      rsp_reliability
);

   localparam int STAGES = 4;

   // Valid and reliable flags travel alongside the data of each stage.
   logic [STAGES-1:0]       valid_ff;
   logic [STAGES-1:0]       valid_in;
   logic [STAGES-1:0]       keep_ff;
   logic [STAGES-1:0]       keep_in;
   logic [STAGES-1:0]       load;
   stage_en_type            stage_en;

   logic [PHASE_BITS-1:0]   lane_a [LANE_COUNT];
   logic [PHASE_BITS-1:0]   lane_b [LANE_COUNT];
   logic [2*PHASE_BITS-1:0] lane_square [LANE_COUNT];

   // A stage loads when it is empty or when the stage after it moves on.
   always_comb begin
      load[STAGES-1] = !valid_ff[STAGES-1] || rsp_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
      stage_en.magnitude = load[0];
      stage_en.square    = load[1];
      stage_en.pair_sum  = load[2];
      stage_en.total     = load[3];

      valid_in = valid_ff;
      keep_in  = keep_ff;
      for (int k = 0; k < STAGES; k++) begin
         if (load[k]) begin
            valid_in[k] = (k == 0) ? req_valid : valid_ff[(k == 0) ? 0 : k-1];
            keep_in[k]  = (k == 0) ? (req_window_masked == 9'd0)
                                   : keep_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      keep_ff <= keep_in;
   end

   // Neighbours on each line through the centre: above or left first.
   always_comb begin
      lane_a[DIR_HORIZONTAL] = req_phase_left;
      lane_b[DIR_HORIZONTAL] = req_phase_right;
      lane_a[DIR_VERTICAL]   = req_phase_up;
      lane_b[DIR_VERTICAL]   = req_phase_down;
      lane_a[DIR_DIAGONAL]   = req_phase_up_left;
      lane_b[DIR_DIAGONAL]   = req_phase_down_right;
      lane_a[DIR_ANTI_DIAG]  = req_phase_up_right;
      lane_b[DIR_ANTI_DIAG]  = req_phase_down_left;
   end

   for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
      prs_lane #(
         .PHASE_BITS (PHASE_BITS)
      ) u_lane (
         .clock    (clock),
         .stage_en (stage_en),
         .phase_a  (lane_a[g]),
         .phase_c  (req_phase_center),
         .phase_b  (lane_b[g]),
         .square   (lane_square[g])
      );
   end

   // The reliable flag of the pair-sum stage gates the final sum.
   prs_merge #(
      .PHASE_BITS (PHASE_BITS)
   ) u_merge (
      .clock    (clock),
      .stage_en (stage_en),
      .square   (lane_square),
      .keep     (keep_ff[STAGES-2]),
      .total    (rsp_reliability)
   );

   assign req_ready    = load[0];
   assign rsp_valid    = valid_ff[STAGES-1];
   assign rsp_reliable = keep_ff[STAGES-1];

endmodule

`default_nettype wire

// ===== sv/prs_checker.sv =====
`default_nettype none

module prs_checker
   import prs_pkg::*;
#(
   parameter int PHASE_BITS = PHASE_BITS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_ready,
   input  wire logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire logic                    rsp_reliable,
   input  wire logic [2*PHASE_BITS+1:0] rsp_reliability
);

   // Nothing comes out in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output word present right after reset");

   // A word for a masked window always reports zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_reliable) |-> (rsp_reliability == '0))
      else $error("masked window reports nonzero reliability");

   // With the output free to move, the pipeline must take a new word.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input stalled while output is free");

   // A stalled output word holds its value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_reliable) && $stable(rsp_reliability)))
      else $error("stalled output word changed");

endmodule

bind phase_reliability_stencil prs_checker #(
   .PHASE_BITS (PHASE_BITS)
) u_prs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_reliable    (rsp_reliable),
   .rsp_reliability (rsp_reliability)
);

`default_nettype wire
